// ===== hdl/mavh_pkg.sv =====
// Shared constants, payload types and state codes of the moving-average level unit.
`default_nettype none

package mavh_pkg;

   // History ring geometry.
   localparam int RING_DEPTH = 32;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // Field widths.
   localparam int SAMPLE_W  = 12;
   localparam int WIN_W     = 5;
   localparam int LEVEL_W   = 3;
   localparam int SUM_W     = SAMPLE_W + CNT_W;
   localparam int CSR_IDX_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_THREE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_FOUR  = 3'd5;

   // Register values after reset.
   localparam logic [WIN_W-1:0]    RST_WINDOW_LEN      = 5'd30;
   localparam logic [SAMPLE_W-1:0] RST_DEADBAND        = 12'd50;
   localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_ONE   = 12'd2300;
   localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_TWO   = 12'd2500;
   localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_THREE = 12'd2700;
   localparam logic [SAMPLE_W-1:0] RST_THRESHOLD_FOUR  = 12'd2900;

   // Level codes.
   localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
      logic [SAMPLE_W-1:0] sample_d;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [SAMPLE_W-1:0] held_value;
   } rsp_payload_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_HYST,
      ST_FINISH
   } state_type;

   // Access request to the history ring.
   typedef struct packed {
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
   } ring_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/mavh_ring.sv =====
// History ring memory with per-entry valid bits so that unwritten entries read as zero.
`default_nettype none

module mavh_ring (
   input  wire                              clock,
   input  wire                              reset,
   input  mavh_pkg::ring_cmd_type           ring_cmd,
   output logic [mavh_pkg::SAMPLE_W-1:0]    rd_data
);
   import mavh_pkg::*;

   logic [SAMPLE_W-1:0]   mem_ff [RING_DEPTH];
   logic [SAMPLE_W-1:0]   mem_q_ff;
   logic [RING_DEPTH-1:0] valid_ff;
   logic                  hit_ff;

   // Storage array: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ring_cmd.wr_en) begin
         mem_ff[ring_cmd.wr_addr] <= ring_cmd.wr_data;
      end
      if (ring_cmd.rd_en) begin
         mem_q_ff <= mem_ff[ring_cmd.rd_addr];
      end
   end

   // Valid bits are cleared by reset; the read captures the bit of its entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (ring_cmd.wr_en) begin
            valid_ff[ring_cmd.wr_addr] <= 1'b1;
         end
         if (ring_cmd.rd_en) begin
            hit_ff <= valid_ff[ring_cmd.rd_addr];
         end
      end
   end

   // An entry never written reads as zero.
   assign rd_data = hit_ff ? mem_q_ff : '0;

endmodule

`default_nettype wire

// ===== hdl/mavh_divider.sv =====
// Restoring serial divider: one quotient bit per cycle.
`default_nettype none

module mavh_divider (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire  [mavh_pkg::SUM_W-1:0]    dividend,
   input  wire  [mavh_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [mavh_pkg::SUM_W-1:0]    quotient
);
   import mavh_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dsr_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              take;

   // One shift-and-subtract step; the remainder stays below the divisor.
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      take  = (trial >= {1'b0, dsr_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], take};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath flops.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/moving_average_hysteresis_level_unit.sv =====
// Top level: four-sample mean, windowed moving average, hysteresis and five-level quantiser.
//
// Each request beat carries four 12-bit readings; their truncated mean is written into a
// 32-entry history ring and the first window_len entries are summed and divided by
// window_len, after which the held value follows the average only when the two differ by
// more than the deadband, and the held value is sorted into levels 0 to 4. The ring is
// walked one entry a cycle through its single read port, and the quotient comes from a
// serial divider at one bit a cycle over 18 bits. The block takes one item at a time;
// req_ready is high while it is idle, also while a finished response still waits in the
// output register. The ring needs no clearing pass after reset, and configuration writes
// are always accepted.
`default_nettype none

module moving_average_hysteresis_level_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  mavh_pkg::req_payload_type          req_payload,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output mavh_pkg::rsp_payload_type          rsp_payload,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [mavh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [mavh_pkg::SAMPLE_W-1:0]      csr_data
);
   import mavh_pkg::*;

   logic [WIN_W-1:0]    window_len_ff;
   logic [SAMPLE_W-1:0] deadband_ff;
   logic [SAMPLE_W-1:0] threshold_one_ff;
   logic [SAMPLE_W-1:0] threshold_two_ff;
   logic [SAMPLE_W-1:0] threshold_three_ff;
   logic [SAMPLE_W-1:0] threshold_four_ff;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    wp_ff, wp_in;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic [CNT_W-1:0]    win_eff;
   logic [SAMPLE_W+1:0] sum4;
   logic [SAMPLE_W-1:0] mean4;
   logic [IDX_W:0]      wp_plus;
   logic [SAMPLE_W-1:0] diff;
   logic [LEVEL_W-1:0]  level;
   ring_cmd_type        ring_cmd;
   logic [SAMPLE_W-1:0] rd_data;
   logic                div_start;
   logic                div_done;
   logic [SUM_W-1:0]    div_quotient;

   mavh_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_cmd (ring_cmd),
      .rd_data  (rd_data)
   );

   mavh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (win_eff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Configuration registers; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff      <= RST_WINDOW_LEN;
         deadband_ff        <= RST_DEADBAND;
         threshold_one_ff   <= RST_THRESHOLD_ONE;
         threshold_two_ff   <= RST_THRESHOLD_TWO;
         threshold_three_ff <= RST_THRESHOLD_THREE;
         threshold_four_ff  <= RST_THRESHOLD_FOUR;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_LEN:      window_len_ff      <= csr_data[WIN_W-1:0];
            CSR_DEADBAND:        deadband_ff        <= csr_data;
            CSR_THRESHOLD_ONE:   threshold_one_ff   <= csr_data;
            CSR_THRESHOLD_TWO:   threshold_two_ff   <= csr_data;
            CSR_THRESHOLD_THREE: threshold_three_ff <= csr_data;
            CSR_THRESHOLD_FOUR:  threshold_four_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Effective window: zero counts as one, and the ring depth is the upper limit.
   always_comb begin
      if (window_len_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (int'(window_len_ff) > RING_DEPTH) begin
         win_eff = CNT_W'(RING_DEPTH);
      end else begin
         win_eff = CNT_W'(window_len_ff);
      end
   end

   // Mean of the four readings, truncated.
   assign sum4 = {2'b00, req_payload.sample_a} + {2'b00, req_payload.sample_b}
               + {2'b00, req_payload.sample_c} + {2'b00, req_payload.sample_d};
   assign mean4   = sum4[SAMPLE_W+1:2];
   assign wp_plus = {1'b0, wp_ff} + (IDX_W + 1)'(1);

   // Distance between the new average and the held value.
   assign diff = (avg_ff > held_ff) ? (avg_ff - held_ff) : (held_ff - avg_ff);

   // Thresholds are tested in order; the first one above the held value decides.
   always_comb begin
      if (held_ff < threshold_one_ff) begin
         level = LEVEL_0;
      end else if (held_ff < threshold_two_ff) begin
         level = LEVEL_1;
      end else if (held_ff < threshold_three_ff) begin
         level = LEVEL_2;
      end else if (held_ff < threshold_four_ff) begin
         level = LEVEL_3;
      end else begin
         level = LEVEL_4;
      end
   end

   // Sequencer state and control flops.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         held_ff      <= '0;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         held_ff      <= held_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath flops.
   always_ff @(posedge clock) begin
      acc_ff         <= acc_in;
      avg_ff         <= avg_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Next state: write the mean, walk the window, divide, apply hysteresis, respond.
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      held_in        = held_ff;
      avg_in         = avg_ff;
      acc_in         = acc_ff;
      issue_in       = issue_ff;
      rd_pend_in     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      ring_cmd       = '0;
      div_start      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ring_cmd.wr_en   = 1'b1;
               ring_cmd.wr_addr = wp_ff;
               ring_cmd.wr_data = mean4;
               if (int'(wp_plus) >= int'(win_eff)) begin
                  wp_in = '0;
               end else begin
                  wp_in = wp_plus[IDX_W-1:0];
               end
               acc_in   = '0;
               issue_in = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (issue_ff < win_eff) begin
               ring_cmd.rd_en   = 1'b1;
               ring_cmd.rd_addr = issue_ff[IDX_W-1:0];
               issue_in         = issue_ff + CNT_W'(1);
               rd_pend_in       = 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in = acc_ff + SUM_W'(rd_data);
            end
            if ((issue_ff == win_eff) && !rd_pend_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quotient[SAMPLE_W-1:0];
               state_in = ST_HYST;
            end
         end
         ST_HYST: begin
            if (diff > deadband_ff) begin
               held_in = avg_ff;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.level      = level;
               rsp_payload_in.held_value = held_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // An accepted beat starts the window walk and closes the request side.
   a_accept_starts_sum: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SUM && !req_ready))
      else $error("accepted beat did not start the window walk");

   // The held value only moves in the hysteresis step.
   a_held_only_in_hyst: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_HYST) |=> $stable(held_ff))
      else $error("held value changed outside the hysteresis step");

   // The window average always fits the sample width.
   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_quotient[SUM_W-1:SAMPLE_W] == '0))
      else $error("window average exceeds the sample range");

   // After an item the write position lies inside the window.
   a_wp_in_window: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (int'(wp_ff) < int'(win_eff)))
      else $error("write position outside the window");

   // A presented response never carries an undefined level code.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.level <= LEVEL_4))
      else $error("response level out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/moving_average_hysteresis_level_unit_tb.sv =====
// Self-checking testbench for the moving-average level unit with its own filter predictor.
`timescale 1ns / 1ps

module moving_average_hysteresis_level_unit_tb;
   import mavh_pkg::*;

   // Run shape.
   localparam int IDLE_PCT       = 21;
   localparam int HOLD_CYCLES    = 400;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 150;
   localparam int WALK_NOISE     = 60;

   // Indexes that decode to no register.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 3'd7;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [SAMPLE_W-1:0]   csr_data    = '0;

   // Predictor copy of the registers and the filter state.
   logic [WIN_W-1:0]      cfg_window;
   logic [SAMPLE_W-1:0]   cfg_deadband;
   logic [SAMPLE_W-1:0]   cfg_thr_one;
   logic [SAMPLE_W-1:0]   cfg_thr_two;
   logic [SAMPLE_W-1:0]   cfg_thr_three;
   logic [SAMPLE_W-1:0]   cfg_thr_four;
   logic [SAMPLE_W-1:0]   history_copy [RING_DEPTH];
   int unsigned           next_slot;
   logic [SAMPLE_W-1:0]   held_copy;

   rsp_payload_type       expected_readouts [$];
   int                    mismatch_count = 0;
   int                    idle_pct = IDLE_PCT;
   int                    walk_level = 2048;
   int                    stall_requests = 0;
   int                    stall_served = 0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;

   moving_average_hysteresis_level_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Advance the predicted filter by one reading and return the level and held value.
   function automatic rsp_payload_type advance_filter(input req_payload_type item);
      int unsigned     span;
      int unsigned     total;
      int unsigned     four_sum;
      logic [SAMPLE_W-1:0] mean4;
      logic [SAMPLE_W-1:0] window_mean;
      logic [SAMPLE_W-1:0] distance;
      rsp_payload_type outcome;
      span = (cfg_window == 0) ? 1 : cfg_window;
      if (span > RING_DEPTH) span = RING_DEPTH;
      four_sum = item.sample_a + item.sample_b + item.sample_c + item.sample_d;
      mean4 = SAMPLE_W'(four_sum / 4);
      if (next_slot >= RING_DEPTH) next_slot = 0;
      history_copy[next_slot] = mean4;
      total = 0;
      for (int k = 0; k < span; k++) total += history_copy[k];
      window_mean = SAMPLE_W'(total / span);
      next_slot++;
      if (next_slot >= span) next_slot = 0;
      distance = (window_mean > held_copy) ? window_mean - held_copy : held_copy - window_mean;
      if (distance > cfg_deadband) held_copy = window_mean;
      // Thresholds are tried in order; the first one above the held value decides.
      if (held_copy < cfg_thr_one)        outcome.level = LEVEL_0;
      else if (held_copy < cfg_thr_two)   outcome.level = LEVEL_1;
      else if (held_copy < cfg_thr_three) outcome.level = LEVEL_2;
      else if (held_copy < cfg_thr_four)  outcome.level = LEVEL_3;
      else                                outcome.level = LEVEL_4;
      outcome.held_value = held_copy;
      return outcome;
   endfunction

   function automatic req_payload_type reading_of(input logic [SAMPLE_W-1:0] a, b, c, d);
      req_payload_type item;
      item.sample_a = a;
      item.sample_b = b;
      item.sample_c = c;
      item.sample_d = d;
      return item;
   endfunction

   // Mostly a slowly wandering level with noise, sometimes a reading of pure noise.
   function automatic req_payload_type drifting_reading();
      int              s [4];
      req_payload_type item;
      if ($urandom_range(0, 9) == 0) begin
         item = reading_of(SAMPLE_W'($urandom_range(0, 4095)),
                           SAMPLE_W'($urandom_range(0, 4095)),
                           SAMPLE_W'($urandom_range(0, 4095)),
                           SAMPLE_W'($urandom_range(0, 4095)));
      end else begin
         if ($urandom_range(0, 31) == 0) walk_level = $urandom_range(0, 4095);
         else walk_level += int'($urandom_range(0, 160)) - 80;
         if (walk_level < 0) walk_level = 0;
         if (walk_level > 4095) walk_level = 4095;
         for (int k = 0; k < 4; k++) begin
            s[k] = walk_level + int'($urandom_range(0, 2 * WALK_NOISE)) - WALK_NOISE;
            if (s[k] < 0) s[k] = 0;
            if (s[k] > 4095) s[k] = 4095;
         end
         item = reading_of(s[0][SAMPLE_W-1:0], s[1][SAMPLE_W-1:0],
                           s[2][SAMPLE_W-1:0], s[3][SAMPLE_W-1:0]);
      end
      return item;
   endfunction

   // Offer one request beat after a random gap and record its predicted response.
   task automatic send_reading(input req_payload_type item);
      int unsigned gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(0, 19) == 0) gap = $urandom_range(1, 60);
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_readouts.push_back(advance_filter(item));
   endtask

   // Write one register; the caller lowers csr_valid after its last write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [SAMPLE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_WINDOW_LEN:      cfg_window    = data[WIN_W-1:0];
         CSR_DEADBAND:        cfg_deadband  = data;
         CSR_THRESHOLD_ONE:   cfg_thr_one   = data;
         CSR_THRESHOLD_TWO:   cfg_thr_two   = data;
         CSR_THRESHOLD_THREE: cfg_thr_three = data;
         CSR_THRESHOLD_FOUR:  cfg_thr_four  = data;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [SAMPLE_W-1:0] window_word, band,
                                 first, second, third, fourth);
      write_reg(CSR_WINDOW_LEN, window_word);
      write_reg(CSR_DEADBAND, band);
      write_reg(CSR_THRESHOLD_ONE, first);
      write_reg(CSR_THRESHOLD_TWO, second);
      write_reg(CSR_THRESHOLD_THREE, third);
      write_reg(CSR_THRESHOLD_FOUR, fourth);
      csr_valid <= 1'b0;
   endtask

   // Stop offering and wait until every predicted response has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_readouts.size() != 0);
   endtask

   // Reset settings: zero readings, full scale, truncation of the four-sample mean.
   task automatic test_reset_defaults();
      send_reading(reading_of(12'd0, 12'd0, 12'd0, 12'd0));
      send_reading(reading_of(12'd4095, 12'd4095, 12'd4095, 12'd4095));
      send_reading(reading_of(12'd4095, 12'd4095, 12'd4095, 12'd4094));
      send_reading(reading_of(12'd1, 12'd1, 12'd1, 12'd0));
      send_reading(reading_of(12'hAAA, 12'h555, 12'hAAA, 12'h555));
      drain_responses();
   endtask

   // A difference equal to the deadband keeps the held value; one more replaces it.
   task automatic test_hysteresis_edge();
      apply_settings(12'd1, 12'd100, 12'd1000, 12'd1050, 12'd1101, 12'd2000);
      send_reading(reading_of(12'd1000, 12'd1000, 12'd1000, 12'd1000));
      send_reading(reading_of(12'd1100, 12'd1100, 12'd1100, 12'd1100));
      send_reading(reading_of(12'd900, 12'd900, 12'd900, 12'd900));
      send_reading(reading_of(12'd1101, 12'd1101, 12'd1101, 12'd1101));
      drain_responses();
   endtask

   // A zero window acts as one; the widest deadband freezes the held value.
   task automatic test_window_extremes();
      apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      send_reading(reading_of(12'd4095, 12'd4095, 12'd4095, 12'd4095));
      send_reading(reading_of(12'd0, 12'd0, 12'd0, 12'd0));
      drain_responses();
      apply_settings(12'd31, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      send_reading(reading_of(12'd4095, 12'd4095, 12'd4095, 12'd4095));
      send_reading(reading_of(12'd0, 12'd4095, 12'd0, 12'd4095));
      drain_responses();
   endtask

   // Thresholds out of order: the first one above the held value wins.
   task automatic test_unordered_thresholds();
      apply_settings(12'd1, 12'd0, 12'd2000, 12'd1000, 12'd3000, 12'd2500);
      send_reading(reading_of(12'd1500, 12'd1500, 12'd1500, 12'd1500));
      send_reading(reading_of(12'd3200, 12'd3200, 12'd3200, 12'd3200));
      send_reading(reading_of(12'd500, 12'd500, 12'd500, 12'd500));
      drain_responses();
   endtask

   // Shrink the window below the write position; unused indexes must change nothing.
   task automatic test_window_shrink();
      apply_settings(12'd8, 12'd0, RST_THRESHOLD_ONE, RST_THRESHOLD_TWO,
                     RST_THRESHOLD_THREE, RST_THRESHOLD_FOUR);
      for (int k = 0; k < 6; k++) send_reading(drifting_reading());
      drain_responses();
      write_reg(CSR_UNUSED_LOW, SAMPLE_W'($urandom_range(0, 4095)));
      write_reg(CSR_UNUSED_HIGH, SAMPLE_W'($urandom_range(0, 4095)));
      write_reg(CSR_WINDOW_LEN, 12'd3);
      csr_valid <= 1'b0;
      send_reading(drifting_reading());
      send_reading(drifting_reading());
      drain_responses();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      stall_requests++;
      for (int k = 0; k < 10; k++) send_reading(drifting_reading());
      drain_responses();
   endtask

   // One phase of random settings followed by wandering readings.
   task automatic run_random_phase(input int phase);
      int t [4];
      int swap;
      int win;
      int band;
      win = $urandom_range(0, 31);
      band = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 150);
      for (int k = 0; k < 4; k++) t[k] = $urandom_range(0, 4095);
      // Mostly ascending thresholds so that every level is reachable.
      if ($urandom_range(0, 4) != 0) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3 - i; j++) begin
               if (t[j] > t[j + 1]) begin
                  swap = t[j];
                  t[j] = t[j + 1];
                  t[j + 1] = swap;
               end
            end
         end
      end
      case (phase)
         0: begin
            win  = 31;
            band = 0;
         end
         1: begin
            win  = 1;
            band = 0;
         end
         2: win = 0;
         3: idle_pct = 0;
         default: ;
      endcase
      apply_settings({(SAMPLE_W - WIN_W)'($urandom_range(0, 127)), win[WIN_W-1:0]},
                     band[SAMPLE_W-1:0],
                     t[0][SAMPLE_W-1:0], t[1][SAMPLE_W-1:0],
                     t[2][SAMPLE_W-1:0], t[3][SAMPLE_W-1:0]);
      for (int k = 0; k < PHASE_ITEMS; k++) send_reading(drifting_reading());
      drain_responses();
      idle_pct = IDLE_PCT;
   endtask

   // Response readiness: random idling, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // Compare each response beat with the oldest prediction.
   always @(posedge clock) begin : check_responses
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readouts.size() == 0) begin
            $error("unexpected response beat: level %0d held_value %0d",
                   rsp_payload.level, rsp_payload.held_value);
            mismatch_count++;
         end else begin
            want = expected_readouts.pop_front();
            if (rsp_payload.level !== want.level) begin
               $error("level: expected %0d, actual %0d", want.level, rsp_payload.level);
               mismatch_count++;
            end
            if (rsp_payload.held_value !== want.held_value) begin
               $error("held_value: expected %0d, actual %0d",
                      want.held_value, rsp_payload.held_value);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      cfg_window    = RST_WINDOW_LEN;
      cfg_deadband  = RST_DEADBAND;
      cfg_thr_one   = RST_THRESHOLD_ONE;
      cfg_thr_two   = RST_THRESHOLD_TWO;
      cfg_thr_three = RST_THRESHOLD_THREE;
      cfg_thr_four  = RST_THRESHOLD_FOUR;
      for (int k = 0; k < RING_DEPTH; k++) history_copy[k] = '0;
      next_slot = 0;
      held_copy = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_hysteresis_edge();
      test_window_extremes();
      test_unordered_thresholds();
      test_window_shrink();
      test_output_backpressure();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) run_random_phase(phase);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_readouts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
